[design/itoa_pkg.sv]
// itoa_pkg: types, constants and character functions for the integer to ascii formatter
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package itoa_pkg;

	// format kinds carried on the cmd field
	localparam logic [1:0] CMD_DEC    = 2'd0;
	localparam logic [1:0] CMD_HEX_LO = 2'd1;
	localparam logic [1:0] CMD_HEX_UP = 2'd2;
	localparam logic [1:0] CMD_PTR    = 2'd3;

	localparam int CMD_W     = 2;
	localparam int VALUE_W   = 64;
	localparam int HEX_W     = 32;
	localparam int CHAR_W    = 8;
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W   = 4;
	localparam int DIGBUF_W  = NUM_DIGITS * DIGIT_W;
	localparam int NDIG_W    = 5;
	localparam int BITCNT_W  = 6;
	localparam int PIDX_W    = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_PREFIX,
		ST_DIGITS
	} state_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX,
		PFX_NIL
	} pfx_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'h0, d};
		end else if (upper) begin
			c = 8'h41 + {4'h0, d} - 8'd10;
		end else begin
			c = 8'h61 + {4'h0, d} - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] prefix_char(input pfx_t k,
			input logic [PIDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		c = 8'h00;
		unique case (k)
			PFX_MINUS: c = 8'h2d;
			PFX_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78;
			PFX_NIL: begin
				unique case (idx)
					3'd0:    c = 8'h28;
					3'd1:    c = 8'h6e;
					3'd2:    c = 8'h69;
					3'd3:    c = 8'h6c;
					3'd4:    c = 8'h29;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// index of the final character of each prefix
	function automatic logic [PIDX_W-1:0] prefix_last(input pfx_t k);
		logic [PIDX_W-1:0] n;
		unique case (k)
			PFX_HEX: n = 3'd1;
			PFX_NIL: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// add-3 correction on every bcd digit ahead of the shift
	function automatic logic [DIGBUF_W-1:0] dabble_adjust(input logic [DIGBUF_W-1:0] d);
		logic [DIGBUF_W-1:0] r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				r[i*DIGIT_W +: DIGIT_W] = d[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

[design/itoa_num_if.sv]
// itoa_num_if: input channel carrying one number and its format kind
// depends on itoa_pkg for field widths
`timescale 1ns / 1ps

interface itoa_num_if;
	logic                          valid;
	logic                          ready;
	logic [itoa_pkg::CMD_W-1:0]    cmd;
	logic [itoa_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

[design/itoa_char_if.sv]
// itoa_char_if: output channel carrying one ascii character and its last mark
// depends on itoa_pkg for field widths
`timescale 1ns / 1ps

interface itoa_char_if;
	logic                          valid;
	logic                          ready;
	logic [itoa_pkg::CHAR_W-1:0]   char_out;
	logic                          last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

[design/integer_to_ascii_formatter_top.sv]
// integer_to_ascii_formatter_top: formats 64-bit decimal/pointer or 32-bit hex text
// depends on itoa_pkg, itoa_num_if and itoa_char_if
//
// channel  dir  payload          request moves
// number   in   cmd, value       one number to format
// chars    out  char_out, last   one character, last set on the final one
//
// decimal: 64 shift-add-3 steps in one shared bcd unit, then leading zero
// skip (one nibble a cycle), prefix and digits at one character a cycle while chars
// is not stalled. hex and pointer skip the conversion; a zero pointer gives (nil).
// number.ready is high only in idle; a stalled chars channel holds the sequencer.
// arst_n clears the sequencer and the output valid.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top (
	input  logic             clk,
	input  logic             arst_n,
	itoa_num_if.sink         number,
	itoa_char_if.source      chars
);

	itoa_pkg::state_t                   state_q, state_d;
	itoa_pkg::pfx_t                     pfx_q;
	logic [itoa_pkg::DIGBUF_W-1:0]      dig_q;
	logic [itoa_pkg::VALUE_W-1:0]       bin_q;
	logic [itoa_pkg::NDIG_W-1:0]        ndig_q;
	logic [itoa_pkg::BITCNT_W-1:0]      bitcnt_q;
	logic [itoa_pkg::PIDX_W-1:0]        pidx_q;
	logic                               upper_q;
	logic                               out_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]        char_q;
	logic                               last_q;

	logic                               accept;
	logic                               out_free;
	logic                               emit;
	logic [itoa_pkg::CHAR_W-1:0]        emit_char;
	logic                               emit_last;
	logic                               skip_done;
	logic                               negative;
	logic [itoa_pkg::VALUE_W-1:0]       magnitude;
	logic [itoa_pkg::DIGIT_W-1:0]       top_digit;

	assign accept    = number.valid && number.ready;
	assign out_free  = !out_valid_q || chars.ready;
	assign negative  = number.value[itoa_pkg::VALUE_W-1];
	assign magnitude = negative ? (~number.value + 64'd1) : number.value;
	assign top_digit = dig_q[itoa_pkg::DIGBUF_W-1 -: itoa_pkg::DIGIT_W];
	assign skip_done = (top_digit != 4'h0) || (ndig_q == 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		number.ready = 1'b0;
		emit         = 1'b0;
		emit_char    = 8'h00;
		emit_last    = 1'b0;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				number.ready = 1'b1;
				if (number.valid) begin
					priority if (number.cmd == itoa_pkg::CMD_DEC) begin
						state_d = itoa_pkg::ST_CONV;
					end else if (number.cmd == itoa_pkg::CMD_PTR && number.value == 64'd0) begin
						state_d = itoa_pkg::ST_PREFIX;
					end else begin
						state_d = itoa_pkg::ST_SKIP;
					end
				end
			end
			itoa_pkg::ST_CONV: begin
				if (bitcnt_q == 6'd0) begin
					state_d = itoa_pkg::ST_SKIP;
				end
			end
			itoa_pkg::ST_SKIP: begin
				if (skip_done) begin
					state_d = (pfx_q != itoa_pkg::PFX_NONE) ? itoa_pkg::ST_PREFIX
						: itoa_pkg::ST_DIGITS;
				end
			end
			itoa_pkg::ST_PREFIX: begin
				emit_char = itoa_pkg::prefix_char(pfx_q, pidx_q);
				emit_last = (pfx_q == itoa_pkg::PFX_NIL) &&
					(pidx_q == itoa_pkg::prefix_last(pfx_q));
				if (out_free) begin
					emit = 1'b1;
					if (pidx_q == itoa_pkg::prefix_last(pfx_q)) begin
						state_d = (pfx_q == itoa_pkg::PFX_NIL) ? itoa_pkg::ST_IDLE
							: itoa_pkg::ST_DIGITS;
					end
				end
			end
			itoa_pkg::ST_DIGITS: begin
				emit_char = itoa_pkg::digit_char(top_digit, upper_q);
				emit_last = (ndig_q == 5'd1);
				if (out_free) begin
					emit = 1'b1;
					if (ndig_q == 5'd1) begin
						state_d = itoa_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = itoa_pkg::ST_IDLE;
		endcase
	end

	// digit buffer, binary shifter and counters
	always_ff @(posedge clk) begin
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (accept) begin
					ndig_q   <= itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS);
					pidx_q   <= '0;
					bitcnt_q <= '1;
					upper_q  <= (number.cmd == itoa_pkg::CMD_HEX_UP);
					bin_q    <= magnitude;
					priority if (number.cmd == itoa_pkg::CMD_DEC) begin
						dig_q <= '0;
						pfx_q <= negative ? itoa_pkg::PFX_MINUS : itoa_pkg::PFX_NONE;
					end else if (number.cmd == itoa_pkg::CMD_PTR) begin
						dig_q <= {16'h0000, number.value};
						pfx_q <= (number.value == 64'd0) ? itoa_pkg::PFX_NIL
							: itoa_pkg::PFX_HEX;
					end else begin
						dig_q <= {48'h0, number.value[itoa_pkg::HEX_W-1:0]};
						pfx_q <= itoa_pkg::PFX_NONE;
					end
				end
			end
			itoa_pkg::ST_CONV: begin
				{dig_q, bin_q} <= {itoa_pkg::dabble_adjust(dig_q), bin_q} << 1;
				bitcnt_q       <= bitcnt_q - 6'd1;
			end
			itoa_pkg::ST_SKIP: begin
				if (!skip_done) begin
					dig_q  <= dig_q << itoa_pkg::DIGIT_W;
					ndig_q <= ndig_q - 5'd1;
				end
			end
			itoa_pkg::ST_PREFIX: begin
				if (emit) begin
					pidx_q <= pidx_q + 3'd1;
				end
			end
			itoa_pkg::ST_DIGITS: begin
				if (emit) begin
					dig_q  <= dig_q << itoa_pkg::DIGIT_W;
					ndig_q <= ndig_q - 5'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign chars.valid    = out_valid_q;
	assign chars.char_out = char_q;
	assign chars.last     = last_q;

endmodule
